// ===== sv/tick_down_counter_timer_unit_defines.svh =====
// Assertion macros shared by the timer RTL.
// TDCT_ASSERT checks a property outside reset; TDCT_ASSERT_ALWAYS also checks it in reset.
`ifndef TICK_DOWN_COUNTER_TIMER_UNIT_DEFINES_SVH
`define TICK_DOWN_COUNTER_TIMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TDCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define TDCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDCT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/tdct_pkg.sv =====
`default_nettype none
package tdct_pkg;

    // Fixed widths of the bus fields
    localparam int DATA_W = 24;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 2;

    // Parameter defaults
    localparam int COUNT_WIDTH_DEF  = 24;
    localparam int PRESCALE_DIV_DEF = 8;

    // Control register bit positions
    localparam int CTRL_EN_BIT      = 0;
    localparam int CTRL_IRQ_BIT     = 1;
    localparam int CTRL_CLKSRC_BIT  = 2;
    localparam int CTRL_ONESHOT_BIT = 3;
    localparam int CTRL_FLAG_BIT    = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        REG_CTRL    = 2'd0,
        REG_RELOAD  = 2'd1,
        REG_CURRENT = 2'd2,
        REG_ELAPSED = 2'd3
    } t_reg_index;

    // One result beat
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pulse;
        logic              reached_zero;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/tdct_core.sv =====
`default_nettype none
`include "tick_down_counter_timer_unit_defines.svh"
module tdct_core
    import tdct_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int PRESCALE_DIV = PRESCALE_DIV_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [IDX_W-1:0]  i_reg_index,
    input  wire logic [DATA_W-1:0] i_write_data,
    output t_result                o_result
);

    localparam int PW = $clog2(PRESCALE_DIV);
    localparam logic [PW-1:0] PRE_LAST = PW'(PRESCALE_DIV - 1);

    logic [COUNT_WIDTH-1:0] r_current, n_current;
    logic [COUNT_WIDTH-1:0] r_reload, n_reload;
    logic                   r_run, n_run;
    logic                   r_irq_en, n_irq_en;
    logic                   r_direct, n_direct;
    logic                   r_one_shot, n_one_shot;
    logic                   r_flag, n_flag;
    logic [PW-1:0]          r_pre, n_pre;

    logic [COUNT_WIDTH-1:0] w_dec;
    logic [COUNT_WIDTH-1:0] w_elapsed;
    logic [31:0]            w_data32;
    logic [31:0]            w_read32;
    logic                   w_take;
    t_result                w_res;

    assign w_dec     = r_current - COUNT_WIDTH'(1);
    assign w_elapsed = r_reload - r_current;
    assign w_data32  = 32'(i_write_data);

    // Next state and result for the beat in the input register
    always_comb begin
        n_current  = r_current;
        n_reload   = r_reload;
        n_run      = r_run;
        n_irq_en   = r_irq_en;
        n_direct   = r_direct;
        n_one_shot = r_one_shot;
        n_flag     = r_flag;
        n_pre      = r_pre;
        w_take     = 1'b0;
        w_read32   = '0;
        w_res      = '0;
        case (t_opcode'(i_opcode))
            OP_TICK: begin
                if (r_run) begin
                    // prescaler only advances in divided mode
                    if (r_direct) begin
                        w_take = 1'b1;
                    end else if (r_pre >= PRE_LAST) begin
                        n_pre  = '0;
                        w_take = 1'b1;
                    end else begin
                        n_pre = r_pre + PW'(1);
                    end
                    if (w_take) begin
                        if (r_current == '0) begin
                            n_current = r_reload;
                        end else begin
                            n_current = w_dec;
                            if (w_dec == '0) begin
                                n_flag             = 1'b1;
                                w_res.reached_zero = 1'b1;
                                w_res.irq_pulse    = r_irq_en;
                                if (r_one_shot) begin
                                    n_run     = 1'b0;
                                    n_irq_en  = 1'b0;
                                    n_reload  = '0;
                                    n_current = '0;
                                end
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                case (t_reg_index'(i_reg_index))
                    REG_CTRL: begin
                        w_read32[CTRL_EN_BIT]      = r_run;
                        w_read32[CTRL_IRQ_BIT]     = r_irq_en;
                        w_read32[CTRL_CLKSRC_BIT]  = r_direct;
                        w_read32[CTRL_ONESHOT_BIT] = r_one_shot;
                        w_read32[CTRL_FLAG_BIT]    = r_flag;
                        n_flag                     = 1'b0;
                    end
                    REG_RELOAD:  w_read32 = 32'(r_reload);
                    REG_CURRENT: w_read32 = 32'(r_current);
                    REG_ELAPSED: w_read32 = 32'(w_elapsed);
                    default:     w_read32 = '0;
                endcase
                w_res.read_data = w_read32[DATA_W-1:0];
            end
            OP_WRITE: begin
                case (t_reg_index'(i_reg_index))
                    REG_CTRL: begin
                        n_run      = i_write_data[CTRL_EN_BIT];
                        n_irq_en   = i_write_data[CTRL_IRQ_BIT];
                        n_direct   = i_write_data[CTRL_CLKSRC_BIT];
                        n_one_shot = i_write_data[CTRL_ONESHOT_BIT];
                    end
                    REG_RELOAD: n_reload = w_data32[COUNT_WIDTH-1:0];
                    REG_CURRENT: begin
                        n_current = '0;
                        n_flag    = 1'b0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_result = w_res;

    // Timer state, updated once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current  <= '0;
            r_reload   <= '0;
            r_run      <= 1'b0;
            r_irq_en   <= 1'b0;
            r_direct   <= 1'b0;
            r_one_shot <= 1'b0;
            r_flag     <= 1'b0;
            r_pre      <= '0;
        end else if (i_fire) begin
            r_current  <= n_current;
            r_reload   <= n_reload;
            r_run      <= n_run;
            r_irq_en   <= n_irq_en;
            r_direct   <= n_direct;
            r_one_shot <= n_one_shot;
            r_flag     <= n_flag;
            r_pre      <= n_pre;
        end
    end

    `TDCT_ASSERT(a_zero_sets_flag, i_clk, i_rst_n,
        (i_fire && w_res.reached_zero) |=> r_flag,
        "count to zero did not set the flag")
    `TDCT_ASSERT(a_one_shot_stop, i_clk, i_rst_n,
        (i_fire && w_res.reached_zero && r_one_shot)
            |=> (!r_run && r_current == '0 && r_reload == '0),
        "one-shot did not stop the timer")
    `TDCT_ASSERT(a_ctrl_read_clears, i_clk, i_rst_n,
        (i_fire && i_opcode == OP_READ && i_reg_index == REG_CTRL) |=> !r_flag,
        "control read did not clear the flag")

endmodule
`default_nettype wire

// ===== sv/tick_down_counter_timer_unit.sv =====
`default_nettype none
`include "tick_down_counter_timer_unit_defines.svh"
// Tick down-counter timer. Every input beat is a clock tick, a register read or a register
// write (opcode and register index in tuser, write value in tdata) and gives exactly one
// result beat: read data in tdata, irq pulse and reached-zero flags in tuser. A beat is taken
// every clock cycle while the output side accepts; it is held in the input register, where it is
// applied to the timer registers, and its result then waits in the output register. Reading
// control clears the count flag; the counter is COUNT_WIDTH bits and the prescaler divides by
// PRESCALE_DIV.
module tick_down_counter_timer_unit
    import tdct_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int PRESCALE_DIV = PRESCALE_DIV_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [23:0] write_data
    input  wire logic [3:0]  i_s_tuser,   // [1:0] opcode, [3:2] reg_index
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [23:0] read_data
    output logic [1:0]       o_m_tuser    // [0] irq_pulse, [1] reached_zero
);

    logic              r_in_valid;
    logic [OP_W-1:0]   r_opcode;
    logic [IDX_W-1:0]  r_reg_index;
    logic [DATA_W-1:0] r_write_data;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_res;
    logic              w_adv;
    logic              w_s_fire;

    // The input beat moves on whenever the output register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (w_s_fire) begin
            r_opcode     <= i_s_tuser[1:0];
            r_reg_index  <= i_s_tuser[3:2];
            r_write_data <= i_s_tdata;
        end
    end

    tdct_core #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .PRESCALE_DIV (PRESCALE_DIV)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_adv),
        .i_opcode     (r_opcode),
        .i_reg_index  (r_reg_index),
        .i_write_data (r_write_data),
        .o_result     (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.read_data;
    assign o_m_tuser  = {r_out.reached_zero, r_out.irq_pulse};

    `TDCT_ASSERT(a_stall_blocks_input, i_clk, i_rst_n,
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready,
        "input taken while both registers are stalled")
    `TDCT_ASSERT(a_bus_no_zero, i_clk, i_rst_n,
        (w_adv && r_opcode != OP_TICK) |=> !r_out.reached_zero && !r_out.irq_pulse,
        "bus access flagged a count to zero")
    `TDCT_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_m_tvalid,
        "result valid right after reset")

endmodule
`default_nettype wire
